// ===== hdl/srlp_pkg.sv =====
// Package for the status reply line parser: result and entry types, byte codes,
// error codes, register indexes and the per-byte line check function.
// Depends on nothing; every other file of the block imports it.
package srlp_pkg;

   localparam int LINE_LIMIT_W  = 16;
   localparam int REPLY_LIMIT_W = 21;
   localparam int STATUS_W      = 10;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 21;

   localparam logic [LINE_LIMIT_W-1:0]  LINE_LIMIT_RESET  = 16'd8192;
   localparam logic [REPLY_LIMIT_W-1:0] REPLY_LIMIT_RESET = 21'd65536;
   localparam logic [STATUS_W-1:0]      SUCCESS_STATUS    = 10'd250;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_LIMIT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLY_LIMIT = 1'b1;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_LONG      = 2'd1;
   localparam logic [1:0] ERR_MALFORMED = 2'd2;
   localparam logic [1:0] ERR_FRAMING   = 2'd3;

   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_DASH  = 8'h2D;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;

   typedef struct packed {
      logic [LINE_LIMIT_W-1:0]  line_limit;
      logic [REPLY_LIMIT_W-1:0] reply_limit;
   } cfg_type;

   typedef struct packed {
      logic [LINE_LIMIT_W-1:0]  line_length;
      logic [REPLY_LIMIT_W-1:0] reply_total;
      logic [STATUS_W-1:0]      status_accum;
      logic [STATUS_W-1:0]      held_status;
      logic                     status_known;
      logic                     cr_pending;
      logic                     final_line;
      logic [1:0]               latched_error;
   } parse_state_type;

   typedef struct packed {
      logic                payload_valid;
      logic [7:0]          payload_byte;
      logic                line_end;
      logic                reply_end;
      logic [STATUS_W-1:0] reply_status;
      logic                status_success;
      logic [1:0]          fault_code;
   } rsp_rec_type;

   // One queue entry holds every result of one byte: one or two records.
   typedef struct packed {
      logic        two;
      rsp_rec_type rec0;
      rsp_rec_type rec1;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   typedef struct packed {
      parse_state_type st;
      logic            has_res;
      rsp_rec_type     rec;
   } step_type;

   function automatic rsp_rec_type make_rec(
      input logic            pv,
      input logic [7:0]      pb,
      input logic            le,
      input logic            re,
      input logic [1:0]      err,
      input parse_state_type st
   );
      rsp_rec_type r;
      r.payload_valid  = pv;
      r.payload_byte   = pb;
      r.line_end       = le;
      r.reply_end      = re;
      r.reply_status   = st.held_status;
      r.status_success = st.status_known && (st.held_status == SUCCESS_STATUS);
      r.fault_code     = err;
      return r;
   endfunction

   // Checks one line byte against the limits and the header rules.
   function automatic step_type line_step(
      input parse_state_type st,
      input logic [7:0]      b,
      input cfg_type         cfg
   );
      step_type                 s;
      logic [LINE_LIMIT_W:0]    len_inc;
      logic [REPLY_LIMIT_W:0]   total_inc;
      logic [LINE_LIMIT_W-1:0]  pos;
      logic [STATUS_W-1:0]      acc_next;
      logic                     is_digit;
      s.st      = st;
      s.has_res = 1'b0;
      s.rec     = '0;
      pos       = st.line_length;
      len_inc   = {1'b0, st.line_length} + 1'b1;
      total_inc = {1'b0, st.reply_total} + 1'b1;
      is_digit  = (b >= BYTE_ZERO) && (b <= BYTE_NINE);
      acc_next  = {st.status_accum[6:0], 3'b000} + {st.status_accum[8:0], 1'b0}
                  + {6'd0, b[3:0]};
      if (len_inc > {1'b0, cfg.line_limit}) begin
         s.st.latched_error = ERR_LONG;
         s.has_res = 1'b1;
         s.rec = make_rec(1'b0, 8'd0, 1'b0, 1'b0, ERR_LONG, s.st);
      end else if (total_inc > {1'b0, cfg.reply_limit}) begin
         s.st.latched_error = ERR_MALFORMED;
         s.has_res = 1'b1;
         s.rec = make_rec(1'b0, 8'd0, 1'b0, 1'b0, ERR_MALFORMED, s.st);
      end else begin
         s.st.line_length = len_inc[LINE_LIMIT_W-1:0];
         s.st.reply_total = total_inc[REPLY_LIMIT_W-1:0];
         if (pos < 16'd3) begin
            if (!is_digit) begin
               s.st.latched_error = ERR_MALFORMED;
               s.has_res = 1'b1;
               s.rec = make_rec(1'b0, 8'd0, 1'b0, 1'b0, ERR_MALFORMED, s.st);
            end else begin
               s.st.status_accum = acc_next;
               if (pos == 16'd2) begin
                  if (!st.status_known) begin
                     s.st.held_status  = acc_next;
                     s.st.status_known = 1'b1;
                  end else if (acc_next != st.held_status) begin
                     s.st.latched_error = ERR_FRAMING;
                     s.has_res = 1'b1;
                     s.rec = make_rec(1'b0, 8'd0, 1'b0, 1'b0, ERR_FRAMING, s.st);
                  end
               end
            end
         end else if (pos == 16'd3) begin
            if (b == BYTE_DASH) begin
               s.st.final_line = 1'b0;
            end else if (b == BYTE_SPACE) begin
               s.st.final_line = 1'b1;
            end else begin
               s.st.latched_error = ERR_FRAMING;
               s.has_res = 1'b1;
               s.rec = make_rec(1'b0, 8'd0, 1'b0, 1'b0, ERR_FRAMING, s.st);
            end
         end else begin
            s.has_res = 1'b1;
            s.rec = make_rec(1'b1, b, 1'b0, 1'b0, ERR_NONE, s.st);
         end
      end
      return s;
   endfunction

endpackage

// ===== hdl/srlp_ifs.sv =====
// Handshake interfaces of the status reply line parser: the byte request
// channel and the result channel. Depends on srlp_pkg.
interface srlp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface srlp_rsp_if import srlp_pkg::*; ;
   logic                valid;
   logic                ready;
   logic                payload_valid;
   logic [7:0]          payload_byte;
   logic                line_end;
   logic                reply_end;
   logic [STATUS_W-1:0] reply_status;
   logic                status_success;
   logic [1:0]          fault_code;
   logic                last;

   modport source (output valid, output payload_valid, output payload_byte,
                   output line_end, output reply_end, output reply_status,
                   output status_success, output fault_code, output last,
                   input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input line_end, input reply_end, input reply_status,
                 input status_success, input fault_code, input last,
                 output ready);
endinterface

// ===== hdl/status_reply_line_parser.sv =====
// Top level of the status reply line parser: input register, configuration
// registers, parse engine and result queue. Depends on srlp_pkg and srlp_ifs.
//
// The parser takes one received byte per word on the req channel and can take
// a new byte in every clock cycle while the result queue has room. Each byte
// goes first into an input register; in the next cycle the parse engine checks
// it against the line and reply state and produces zero, one or two result
// words, which enter the result queue together as one entry. The first result
// word of a byte can be taken on rsp once that entry is in the queue. Header
// bytes and a CR that still waits for its LF produce no word; a lone CR
// followed by a body byte produces two. The result channel moves one word per
// cycle while rsp is ready, so a stream in which bytes produce two words runs
// at the pace of the rsp side, and req stalls once the queue (QUEUE_DEPTH
// entries) cannot take the byte in the input register plus one more. The word
// marked last is the final one caused by its byte. Errors latch until reset:
// afterwards every byte returns exactly one word that carries the latched
// error code. The line and reply limits are written through the csr port at
// index 0 and 1 and should only change while no byte is in flight.
module status_reply_line_parser import srlp_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   srlp_req_if.sink               req,
   srlp_rsp_if.source             rsp,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cfg_type          cfg;
   push_type         push;
   logic [CNT_W-1:0] count;
   logic             byte_vld_ff;
   logic             byte_vld_in;
   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;

   // Room must remain for the byte already in the input register and the new one.
   assign req.ready = ({1'b0, count} + {{CNT_W{1'b0}}, byte_vld_ff})
                      < (CNT_W + 1)'(QUEUE_DEPTH);

   assign byte_vld_in = req.valid && req.ready;
   assign byte_in     = req.rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
      end else begin
         byte_vld_ff <= byte_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_vld_in) begin
         byte_ff <= byte_in;
      end
   end

   srlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srlp_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .byte_vld (byte_vld_ff),
      .byte_val (byte_ff),
      .cfg      (cfg),
      .push     (push)
   );

   srlp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .count (count),
      .rsp   (rsp)
   );

endmodule

// ===== hdl/srlp_csr.sv =====
// Configuration registers of the status reply line parser (line and reply limits).
// Depends on srlp_pkg.
module srlp_csr import srlp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINE_LIMIT:  cfg_in.line_limit  = csr_wdata[LINE_LIMIT_W-1:0];
            CSR_REPLY_LIMIT: cfg_in.reply_limit = csr_wdata[REPLY_LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_limit  <= LINE_LIMIT_RESET;
         cfg_ff.reply_limit <= REPLY_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/srlp_engine.sv =====
// Parse engine: holds the line and reply state and turns one registered byte
// into zero, one or two result records per cycle. Depends on srlp_pkg.
module srlp_engine import srlp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_vld,
   input  logic [7:0] byte_val,
   input  cfg_type    cfg,
   output push_type   push
);

   parse_state_type st_ff;
   parse_state_type st_in;
   rsp_rec_type     r0;
   rsp_rec_type     r1;
   logic [1:0]      n;

   always_comb begin
      step_type stp;
      logic     proceed;
      st_in   = st_ff;
      r0      = '0;
      r1      = '0;
      n       = 2'd0;
      stp     = '0;
      proceed = 1'b0;
      if (byte_vld) begin
         if (st_ff.latched_error != ERR_NONE) begin
            r0 = make_rec(1'b0, 8'd0, 1'b0, 1'b0, st_ff.latched_error, st_ff);
            n  = 2'd1;
         end else begin
            proceed = 1'b1;
            if (st_ff.cr_pending) begin
               st_in.cr_pending = 1'b0;
               if (byte_val == BYTE_LF) begin
                  // CR LF closes the line; a header shorter than four is malformed.
                  proceed = 1'b0;
                  n       = 2'd1;
                  if (st_in.line_length < 16'd4) begin
                     st_in.latched_error = ERR_MALFORMED;
                     r0 = make_rec(1'b0, 8'd0, 1'b0, 1'b0, ERR_MALFORMED, st_in);
                  end else begin
                     r0 = make_rec(1'b0, 8'd0, 1'b1, st_in.final_line, ERR_NONE, st_in);
                     st_in.line_length  = '0;
                     st_in.status_accum = '0;
                     if (st_in.final_line) begin
                        st_in.reply_total  = '0;
                        st_in.held_status  = '0;
                        st_in.status_known = 1'b0;
                     end
                     st_in.final_line = 1'b0;
                  end
               end else begin
                  // A lone CR is an ordinary line byte, handled ahead of this one.
                  stp   = line_step(st_in, BYTE_CR, cfg);
                  st_in = stp.st;
                  if (stp.has_res) begin
                     r0 = stp.rec;
                     n  = 2'd1;
                  end
                  if (st_in.latched_error != ERR_NONE) begin
                     proceed = 1'b0;
                  end
               end
            end
            if (proceed) begin
               if (byte_val == BYTE_CR) begin
                  st_in.cr_pending = 1'b1;
               end else begin
                  stp   = line_step(st_in, byte_val, cfg);
                  st_in = stp.st;
                  if (stp.has_res) begin
                     if (n == 2'd0) begin
                        r0 = stp.rec;
                     end else begin
                        r1 = stp.rec;
                     end
                     n = n + 2'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign push.push       = byte_vld && (n != 2'd0);
   assign push.entry.two  = n[1];
   assign push.entry.rec0 = r0;
   assign push.entry.rec1 = r1;

endmodule

// ===== hdl/srlp_queue.sv =====
// Result queue: stores the records of each byte as one entry and hands them
// to the result channel one word at a time. Depends on srlp_pkg, srlp_ifs.
module srlp_queue import srlp_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  push_type                   push,
   output logic [$clog2(DEPTH+1)-1:0] count,
   srlp_rsp_if.source                 rsp
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             sel_ff;
   logic             sel_in;
   entry_type        head;
   rsp_rec_type      rec;
   logic             entry_last;
   logic             take;
   logic             pop;

   assign head       = mem[rd_ptr_ff];
   assign rec        = sel_ff ? head.rec1 : head.rec0;
   assign entry_last = !head.two || sel_ff;
   assign take       = rsp.valid && rsp.ready;
   assign pop        = take && entry_last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sel_in    = sel_ff;
      count_in  = count_ff;
      if (push.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         sel_in    = 1'b0;
      end else if (take) begin
         sel_in = 1'b1;
      end
      if (push.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push) begin
         mem[wr_ptr_ff] <= push.entry;
      end
   end

   assign count              = count_ff;
   assign rsp.valid          = (count_ff != '0);
   assign rsp.payload_valid  = rec.payload_valid;
   assign rsp.payload_byte   = rec.payload_byte;
   assign rsp.line_end       = rec.line_end;
   assign rsp.reply_end      = rec.reply_end;
   assign rsp.reply_status   = rec.reply_status;
   assign rsp.status_success = rec.status_success;
   assign rsp.fault_code     = rec.fault_code;
   assign rsp.last           = entry_last;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for status_reply_line_parser: drives received bytes,
// predicts every result word and compares each field as the words come back.
// Depends on srlp_pkg, the srlp_req_if/srlp_rsp_if interfaces and the block.
module tb import srlp_pkg::*; ;

   // The run stops here if the traffic ever hangs. A correct run, with
   // every byte giving two words and every word waiting out a long stall,
   // stays far below this.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Cycles allowed after the last expected word before the block counts as
   // idle. A byte that gives no word still passes through the input register and the parse engine.
   localparam int DRAIN_CYCLES = 8;

   // Hand-picked opening bytes: a status 000 reply whose first line has the
   // body bytes 0x00 and 0xFF, a lone CR followed by a body byte, a bare LF,
   // then a final line with an empty body; after that a status 250 reply.
   localparam logic [7:0] OPENING [24] = '{
      "0", "0", "0", BYTE_DASH, 8'h00, 8'hFF, BYTE_CR, "A", BYTE_LF,
      BYTE_CR, BYTE_LF,
      "0", "0", "0", BYTE_SPACE, BYTE_CR, BYTE_LF,
      "2", "5", "0", BYTE_SPACE, 8'h7F, BYTE_CR, BYTE_LF
   };

   // Ways to break the byte stream. The first four may follow a clean
   // continuation line, so they are kept at the head of the list.
   typedef enum int {
      FAULT_DIGIT,
      FAULT_SHORT,
      FAULT_STATUS,
      FAULT_SEPARATOR,
      FAULT_LONG,
      FAULT_CR_AT_LIMIT,
      FAULT_REPLY,
      FAULT_BOTH,
      FAULT_TINY_LINE
   } fault_kind_type;

   // One result word as it should appear on the rsp channel.
   typedef struct packed {
      logic                payload_valid;
      logic [7:0]          payload_byte;
      logic                line_end;
      logic                reply_end;
      logic [STATUS_W-1:0] reply_status;
      logic                status_success;
      logic [1:0]          fault_code;
      logic                last;
   } parsed_word_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   srlp_req_if req_ch ();
   srlp_rsp_if rsp_ch ();

   status_reply_line_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Bytes waiting to be offered, and the words that accepted bytes still owe.
   logic [7:0]      rx_backlog [$];
   parsed_word_type words_due [$];

   int failures = 0;
   int cycle_count = 0;

   // ------------------------------------------------------------------
   // Parser prediction. The limits mirror the csr registers; the rest is
   // the parse state, all of it cleared by the single reset.
   // ------------------------------------------------------------------
   logic [LINE_LIMIT_W-1:0]  cfg_line_max  = LINE_LIMIT_RESET;
   logic [REPLY_LIMIT_W-1:0] cfg_reply_max = REPLY_LIMIT_RESET;

   logic [LINE_LIMIT_W-1:0]  line_len    = '0;
   logic [REPLY_LIMIT_W-1:0] reply_bytes = '0;
   logic [STATUS_W-1:0]      status_sum  = '0;
   logic [STATUS_W-1:0]      status_held = '0;
   logic                     status_seen = 1'b0;
   logic                     cr_wait     = 1'b0;
   logic                     last_line   = 1'b0;
   logic [1:0]               err_hold    = ERR_NONE;
   int                       step_words;

   // Every word carries the status held at the moment it is produced.
   function automatic void emit(input logic pv, input logic [7:0] pb, input logic le,
                                input logic re, input logic [1:0] code);
      parsed_word_type w;
      w.payload_valid  = pv;
      w.payload_byte   = pb;
      w.line_end       = le;
      w.reply_end      = re;
      w.reply_status   = status_held;
      w.status_success = status_seen && (status_held == SUCCESS_STATUS);
      w.fault_code     = code;
      w.last           = 1'b0;
      words_due.insert(words_due.size(), w);
      step_words++;
   endfunction

   function automatic void latch_error(input logic [1:0] code);
      err_hold = code;
      emit(1'b0, 8'd0, 1'b0, 1'b0, code);
   endfunction

   // A byte that belongs to the line: limits first, then the header rules.
   function automatic void take_line_byte(input logic [7:0] b);
      logic [LINE_LIMIT_W-1:0] pos;
      pos = line_len;
      if (32'(line_len) + 1 > 32'(cfg_line_max)) begin
         latch_error(ERR_LONG);
         return;
      end
      if (32'(reply_bytes) + 1 > 32'(cfg_reply_max)) begin
         latch_error(ERR_MALFORMED);
         return;
      end
      line_len    = line_len + 1'b1;
      reply_bytes = reply_bytes + 1'b1;
      if (pos < 3) begin
         if (b < BYTE_ZERO || b > BYTE_NINE) begin
            latch_error(ERR_MALFORMED);
            return;
         end
         status_sum = STATUS_W'(int'(status_sum) * 10 + int'(b) - int'(BYTE_ZERO));
         if (pos == 2) begin
            if (!status_seen) begin
               status_held = status_sum;
               status_seen = 1'b1;
            end else if (status_sum != status_held) begin
               latch_error(ERR_FRAMING);
            end
         end
         return;
      end
      if (pos == 3) begin
         if (b == BYTE_DASH) begin
            last_line = 1'b0;
         end else if (b == BYTE_SPACE) begin
            last_line = 1'b1;
         end else begin
            latch_error(ERR_FRAMING);
         end
         return;
      end
      emit(1'b1, b, 1'b0, 1'b0, ERR_NONE);
   endfunction

   // Works out the words that one accepted byte causes and queues them.
   function automatic void parse_rx_byte(input logic [7:0] b);
      logic closed;
      closed = 1'b0;
      step_words = 0;
      if (err_hold != ERR_NONE) begin
         emit(1'b0, 8'd0, 1'b0, 1'b0, err_hold);
      end else begin
         if (cr_wait) begin
            cr_wait = 1'b0;
            if (b == BYTE_LF) begin
               closed = 1'b1;
               if (line_len < 4) begin
                  latch_error(ERR_MALFORMED);
               end else begin
                  emit(1'b0, 8'd0, 1'b1, last_line, ERR_NONE);
                  line_len   = '0;
                  status_sum = '0;
                  if (last_line) begin
                     reply_bytes = '0;
                     status_held = '0;
                     status_seen = 1'b0;
                  end
                  last_line = 1'b0;
               end
            end else begin
               // The held CR turns out to be a lone one and counts as a line byte.
               take_line_byte(BYTE_CR);
            end
         end
         if (!closed && err_hold == ERR_NONE) begin
            if (b == BYTE_CR) begin
               cr_wait = 1'b1;
            end else begin
               take_line_byte(b);
            end
         end
      end
      if (step_words > 0) begin
         words_due[words_due.size() - 1].last = 1'b1;
      end
   endfunction

   // ------------------------------------------------------------------
   // Byte stream generation.
   // ------------------------------------------------------------------
   function automatic void push_digits(input int status, input int count);
      int i;
      for (i = 0; i < count; i++) begin
         rx_backlog.insert(rx_backlog.size(), 8'(int'(BYTE_ZERO)
                           + (status / (i == 0 ? 100 : (i == 1 ? 10 : 1))) % 10));
      end
   endfunction

   function automatic void push_header(input int status, input logic [7:0] sep);
      push_digits(status, 3);
      rx_backlog.insert(rx_backlog.size(), sep);
   endfunction

   // Body bytes without any CR, so that nothing can end the line early.
   function automatic void push_plain(input int count);
      logic [7:0] b;
      repeat (count) begin
         do b = 8'($urandom_range(0, 255)); while (b == BYTE_CR);
         rx_backlog.insert(rx_backlog.size(), b);
      end
   endfunction

   function automatic void push_crlf();
      rx_backlog.insert(rx_backlog.size(), BYTE_CR);
      rx_backlog.insert(rx_backlog.size(), BYTE_LF);
   endfunction

   // Queues one well-formed reply that fits both limits and returns its size
   // in bytes. Bodies are mostly short; where the limit is small, a line is
   // often filled right up to it, which also brings the reply total to its
   // limit on the final line now and then.
   function automatic int queue_reply(input int line_max, input int reply_max);
      int         status;
      int         pick;
      int         nlines;
      int         line_no;
      int         cap;
      int         body_n;
      int         budget;
      int         added;
      logic       final_one;
      logic [7:0] prev;
      logic [7:0] b;
      pick   = $urandom_range(0, 7);
      status = (pick == 0) ? 250 : ((pick == 1) ? 999 : ((pick == 2) ? 0
               : $urandom_range(0, 999)));
      nlines    = $urandom_range(1, 4);
      budget    = reply_max;
      added     = 0;
      line_no   = 0;
      final_one = 1'b0;
      while (!final_one) begin
         // A continuation line must leave room for at least one more header.
         final_one = (line_no == nlines - 1) || (budget < 8);
         cap = line_max - 4;
         if (final_one) begin
            if (budget - 4 < cap) cap = budget - 4;
         end else if (budget - 8 < cap) begin
            cap = budget - 8;
         end
         if (cap <= 64 && $urandom_range(0, 3) == 0) begin
            body_n = cap;
         end else begin
            body_n = $urandom_range(0, cap < 24 ? cap : 24);
         end
         push_header(status, final_one ? BYTE_SPACE : BYTE_DASH);
         prev = 8'd0;
         repeat (body_n) begin
            case ($urandom_range(0, 11))
               0: b = BYTE_CR;
               1: b = BYTE_LF;
               default: b = 8'($urandom_range(0, 255));
            endcase
            // A CR in the body must not be followed by LF, or the line ends.
            if (prev == BYTE_CR && b == BYTE_LF) begin
               b = 8'($urandom_range(int'(BYTE_CR) + 1, 255));
            end
            rx_backlog.insert(rx_backlog.size(), b);
            prev = b;
         end
         push_crlf();
         budget  -= 4 + body_n;
         added   += 6 + body_n;
         line_no++;
      end
      return added;
   endfunction

   function automatic void queue_traffic(input int line_max, input int reply_max,
                                         input int count);
      int total;
      total = 0;
      while (total < count) total += queue_reply(line_max, reply_max);
   endfunction

   // ------------------------------------------------------------------
   // Configuration writes and phase boundaries.
   // ------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input int value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == CSR_LINE_LIMIT) begin
         cfg_line_max = LINE_LIMIT_W'(value);
      end else begin
         cfg_reply_max = REPLY_LIMIT_W'(value);
      end
   endtask

   // Waits until every byte is taken and every word has come back, then lets
   // the pipeline empty of bytes that owe no word. The check runs on the
   // falling edge so that the driver's updates of the rising edge are visible.
   task automatic settle();
      do @(negedge clock);
      while (rx_backlog.size() != 0 || req_ch.valid || words_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The closing phase: one way of breaking the stream, picked at random, then
   // plain noise. Errors latch until reset and reset comes only once, so this
   // has to be the last thing the run does.
   task automatic queue_fault();
      fault_kind_type kind;
      int             status;
      int             line_lim;
      int             reply_lim;
      int             counted;
      logic [7:0]     b;
      kind      = fault_kind_type'($urandom_range(0, int'(FAULT_TINY_LINE)));
      status    = $urandom_range(0, 999);
      line_lim  = int'(LINE_LIMIT_RESET);
      reply_lim = int'(REPLY_LIMIT_RESET);
      case (kind)
         FAULT_LONG, FAULT_CR_AT_LIMIT: begin
            line_lim = $urandom_range(5, 20);
         end
         FAULT_BOTH: begin
            line_lim  = $urandom_range(5, 20);
            reply_lim = line_lim;
         end
         FAULT_REPLY: begin
            reply_lim = $urandom_range(0, 40);
         end
         FAULT_TINY_LINE: begin
            line_lim = $urandom_range(0, 3);
         end
         default: begin
         end
      endcase
      write_csr(CSR_LINE_LIMIT, line_lim);
      write_csr(CSR_REPLY_LIMIT, reply_lim);
      // A status mismatch needs a first line; the header faults take one
      // half of the time so that they also hit continuation lines.
      if (kind == FAULT_STATUS || (kind <= FAULT_SEPARATOR && $urandom_range(0, 1) == 1)) begin
         push_header(status, BYTE_DASH);
         push_plain($urandom_range(0, 4));
         push_crlf();
      end
      case (kind)
         FAULT_DIGIT: begin
            push_digits(status, $urandom_range(0, 2));
            do b = 8'($urandom_range(0, 255));
            while ((b >= BYTE_ZERO && b <= BYTE_NINE) || b == BYTE_CR);
            rx_backlog.insert(rx_backlog.size(), b);
         end
         FAULT_SHORT: begin
            push_digits(status, $urandom_range(0, 3));
            push_crlf();
         end
         FAULT_STATUS: begin
            push_header((status + $urandom_range(1, 999)) % 1000, BYTE_DASH);
         end
         FAULT_SEPARATOR: begin
            push_digits(status, 3);
            do b = 8'($urandom_range(0, 255));
            while (b == BYTE_DASH || b == BYTE_SPACE || b == BYTE_CR);
            rx_backlog.insert(rx_backlog.size(), b);
         end
         FAULT_LONG: begin
            push_header(status, BYTE_SPACE);
            push_plain(line_lim - 4 + $urandom_range(1, 3));
            push_crlf();
         end
         FAULT_CR_AT_LIMIT: begin
            // The line is full when the CR comes; it waits for LF and is then
            // counted as a line byte that does not fit.
            push_header(status, BYTE_SPACE);
            push_plain(line_lim - 4);
            rx_backlog.insert(rx_backlog.size(), BYTE_CR);
            do b = 8'($urandom_range(0, 255)); while (b == BYTE_LF || b == BYTE_CR);
            rx_backlog.insert(rx_backlog.size(), b);
         end
         FAULT_REPLY: begin
            counted = 0;
            while (counted <= reply_lim) begin
               push_header(status, BYTE_DASH);
               push_plain(4);
               push_crlf();
               counted += 8;
            end
         end
         FAULT_BOTH: begin
            // Line and reply limits are equal, so one byte breaks both.
            push_header(status, BYTE_SPACE);
            push_plain(line_lim - 3);
            push_crlf();
         end
         default: begin
            push_header(status, BYTE_SPACE);
            push_plain(2);
            push_crlf();
         end
      endcase
      repeat (20) rx_backlog.insert(rx_backlog.size(), 8'($urandom_range(0, 255)));
   endtask

   // ------------------------------------------------------------------
   // Idle patterns. Mostly back-to-back or short gaps, a few long ones, and
   // now and then a calm stretch with no gap at all.
   // ------------------------------------------------------------------
   function automatic int next_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   // Byte driver. A byte is predicted at the edge where it is accepted; the
   // next one goes out only when the current word has been taken.
   int send_gap = 0;
   int send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) parse_rx_byte(req_ch.rx_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (rx_backlog.size() > 0) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= rx_backlog.pop_front();
               send_gap = next_idle(send_calm);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver. Besides the random stalls it holds ready low once for
   // a long stretch early in the run, while bytes are still being offered,
   // so the result queue fills and the byte side has to stall.
   int  hold_left = 0;
   int  take_calm = 0;
   int  words_taken = 0;
   logic long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) words_taken++;
         if (!long_hold_done && words_taken >= 40) begin
            long_hold_done = 1'b1;
            hold_left = $urandom_range(60, 100);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            hold_left = next_idle(take_calm);
         end
      end
   end

   // Result checker: every accepted word is matched against the oldest
   // outstanding prediction, field by field.
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch_rsp
      parsed_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (words_due.size() == 0) begin
            failures++;
            $error("result word with none expected: payload_byte %0d, fault_code %0d",
                   rsp_ch.payload_byte, rsp_ch.fault_code);
         end else begin
            want = words_due.pop_front();
            check_field("payload_valid", 32'(want.payload_valid),
                        32'(rsp_ch.payload_valid));
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_ch.payload_byte));
            check_field("line_end", 32'(want.line_end), 32'(rsp_ch.line_end));
            check_field("reply_end", 32'(want.reply_end), 32'(rsp_ch.reply_end));
            check_field("reply_status", 32'(want.reply_status), 32'(rsp_ch.reply_status));
            check_field("status_success", 32'(want.status_success),
                        32'(rsp_ch.status_success));
            check_field("fault_code", 32'(want.fault_code), 32'(rsp_ch.fault_code));
            check_field("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status_reply_line_parser verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Test sequence. Each phase ends with the block idle, so the limits are
   // only ever changed between complete replies.
   // ------------------------------------------------------------------
   initial begin : stimulus
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'd0;
      rsp_ch.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_LINE_LIMIT;
      csr_wdata      = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Limits as they come out of reset.
      foreach (OPENING[i]) rx_backlog.insert(rx_backlog.size(), OPENING[i]);
      queue_traffic(int'(cfg_line_max), int'(cfg_reply_max), 250);
      settle();

      // Short line limit and a tight reply limit.
      write_csr(CSR_LINE_LIMIT, 5);
      write_csr(CSR_REPLY_LIMIT, $urandom_range(8, 60));
      queue_traffic(int'(cfg_line_max), int'(cfg_reply_max), 200);
      settle();

      // Line limit at its maximum and the reply limit at 1048576.
      write_csr(CSR_LINE_LIMIT, 65535);
      write_csr(CSR_REPLY_LIMIT, 1048576);
      queue_traffic(int'(cfg_line_max), int'(cfg_reply_max), 250);
      settle();

      // Random small limits, so lines and replies often end right at them.
      write_csr(CSR_LINE_LIMIT, $urandom_range(5, 64));
      write_csr(CSR_REPLY_LIMIT, $urandom_range(8, 300));
      queue_traffic(int'(cfg_line_max), int'(cfg_reply_max), 250);
      settle();

      queue_fault();
      settle();

      if (failures == 0) begin
         $display("status_reply_line_parser verification clean");
      end else begin
         $display("status_reply_line_parser verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/srlp_pkg.sv
hdl/srlp_ifs.sv
hdl/srlp_csr.sv
hdl/srlp_engine.sv
hdl/srlp_queue.sv
hdl/status_reply_line_parser.sv
verif/tb.sv
